/* rtl/sorted_timer_queue_assert.svh */
// ----------------------------------------------------------------------------
// sorted_timer_queue_assert.svh
// Assertion macros shared by the timer queue RTL. Clock aclk, reset aresetn.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define STQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("timer queue check failed");

// Expression holds at every clock edge out of reset.
`define STQ_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("timer queue check failed");

`endif

/* rtl/stq_pkg.sv */
// ----------------------------------------------------------------------------
// stq_pkg
// Word types, request and status codes and cell operation codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stq_pkg;

    // request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_ADJUST = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;
    localparam logic [1:0] REQ_TICK   = 2'd3;

    // result status codes
    localparam logic [2:0] STAT_DONE     = 3'd0;
    localparam logic [2:0] STAT_FULL     = 3'd1;
    localparam logic [2:0] STAT_NOTFOUND = 3'd2;
    localparam logic [2:0] STAT_DUP      = 3'd3;
    localparam logic [2:0] STAT_EXPIRED  = 3'd4;
    localparam logic [2:0] STAT_NONE     = 3'd5;

    // cell operations, broadcast along the chain
    localparam logic [2:0] OP_HOLD    = 3'd0;
    localparam logic [2:0] OP_INSERT  = 3'd1;
    localparam logic [2:0] OP_KILL    = 3'd2;
    localparam logic [2:0] OP_COMPACT = 3'd3;
    localparam logic [2:0] OP_POP     = 3'd4;

    // most timers popped by one tick
    localparam int MAX_OUT = 32;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] timer_id;
        logic [31:0] expire_time;
        logic [31:0] current_time;
    } stq_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] expired_id;
        logic        last;
    } stq_rsp_t;

    // per-cell compare results
    typedef struct packed {
        logic match;    // holds the key id
        logic slot_ge;  // empty, or expiry at or after the key expiry
        logic due;      // holds a timer due at the current time
        logic pair;     // empty with a filled right neighbour
    } stq_cell_stat_t;

    // chain summary for the sequencer
    typedef struct packed {
        logic hit;
        logic full;
        logic head_due;
        logic next_due;
        logic busy;     // a hole still waits to be closed
    } stq_flags_t;

endpackage

/* rtl/sorted_timer_queue.sv */
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Timer queue of up to DEPTH (id, expiry) pairs held sorted in a cell chain.
//
// Input channel s_valid/s_ready/s_data carries one request word: add, adjust,
// delete or tick. Result channel m_valid/m_ready/m_data returns status words;
// the final word caused by a request has last set.
// One request is worked on at a time; s_ready is high while the sequencer
// is idle, even if the previous result word still waits in the output
// register.
// Path, request accepted to result word valid, with a free receiver:
//   add, or an unknown id          word issued from S_DECIDE
//   delete                         kill in S_DECIDE, then hole walk in S_COMPACT
//   adjust                         as delete, insert as the word is issued
//   tick                           first word from S_DECIDE, then one
//                                  word per cycle, at most MAX_OUT words
// The next request is taken in the cycle after the last word is issued, once
// the sequencer is back in idle; in a delete the hole walks one cell a cycle.
// Reset empties every cell and returns the sequencer to idle. A receiver stall
// holds each step that issues a word until the output register can take it; the
// kill and hole walk of a delete or adjust go on. Nothing is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_timer_queue #(
    parameter int DEPTH     = 32,
    parameter int ID_BITS   = 16,
    parameter int TIME_BITS = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  stq_pkg::stq_req_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output stq_pkg::stq_rsp_t m_data
);
    import stq_pkg::*;

    `include "sorted_timer_queue_assert.svh"

    localparam int POP_W = $clog2(MAX_OUT + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_DECIDE  = 2'd1;
    localparam logic [1:0] S_COMPACT = 2'd2;

    logic [1:0]       state_reg, state_next;
    stq_req_t         req_reg;
    logic [POP_W-1:0] pops_reg, pops_next;
    logic             m_valid_reg;
    stq_rsp_t         m_data_reg;

    logic [2:0]           cell_op;
    logic [ID_BITS-1:0]   key_id;
    logic [TIME_BITS-1:0] key_exp;
    logic [TIME_BITS-1:0] now;
    logic [ID_BITS-1:0]   head_id;
    stq_flags_t           flags;

    logic     out_free;
    logic     emit;
    stq_rsp_t emit_data;
    logic     tick_last;

    assign key_id  = ID_BITS'(req_reg.timer_id);
    assign key_exp = TIME_BITS'(req_reg.expire_time);
    assign now     = TIME_BITS'(req_reg.current_time);

    stq_chain #(
        .DEPTH    (DEPTH),
        .ID_BITS  (ID_BITS),
        .TIME_BITS(TIME_BITS)
    ) u_chain (
        .aclk   (aclk),
        .aresetn(aresetn),
        .op     (cell_op),
        .key_id (key_id),
        .key_exp(key_exp),
        .now    (now),
        .head_id(head_id),
        .flags  (flags)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // last popped word: nothing due behind the head, or the burst cap reached
    assign tick_last = !flags.next_due || (pops_reg == POP_W'(MAX_OUT - 1));

    always_comb begin
        state_next = state_reg;
        pops_next  = pops_reg;
        cell_op    = OP_HOLD;
        emit       = 1'b0;
        emit_data  = '{status: STAT_DONE, expired_id: 16'd0, last: 1'b1};
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECIDE;
                    pops_next  = '0;
                end
            end
            S_DECIDE: begin
                unique case (req_reg.req_type)
                    REQ_ADD: begin
                        if (out_free) begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            priority if (flags.hit) begin
                                emit_data.status = STAT_DUP;
                            end else if (flags.full) begin
                                emit_data.status = STAT_FULL;
                            end else begin
                                cell_op = OP_INSERT;
                            end
                        end
                    end
                    REQ_ADJUST, REQ_DELETE: begin
                        if (flags.hit) begin
                            cell_op    = OP_KILL;
                            state_next = S_COMPACT;
                        end else if (out_free) begin
                            emit             = 1'b1;
                            emit_data.status = STAT_NOTFOUND;
                            state_next       = S_IDLE;
                        end
                    end
                    REQ_TICK: begin
                        if (out_free) begin
                            emit = 1'b1;
                            if (flags.head_due && (pops_reg < POP_W'(MAX_OUT))) begin
                                cell_op              = OP_POP;
                                emit_data.status     = STAT_EXPIRED;
                                emit_data.expired_id = 16'(head_id);
                                emit_data.last       = tick_last;
                                pops_next            = pops_reg + POP_W'(1);
                                if (tick_last) begin
                                    state_next = S_IDLE;
                                end
                            end else begin
                                emit_data.status = STAT_NONE;
                                state_next       = S_IDLE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_COMPACT: begin
                if (flags.busy) begin
                    cell_op = OP_COMPACT;
                end else if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (req_reg.req_type == REQ_ADJUST) begin
                        cell_op = OP_INSERT;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pops_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pops_reg  <= pops_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        if (emit) begin
            m_data_reg <= emit_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a hole in the chain exists only while it is being walked out
    `STQ_ASSERT_IMPL(a_hole_only_in_walk, state_reg != S_COMPACT, !flags.busy)
    // an insert never meets a full chain or a stored copy of its id
    `STQ_ASSERT_IMPL(a_insert_has_room, cell_op == OP_INSERT, !flags.full && !flags.hit)
    // a pop always removes a due head
    `STQ_ASSERT_IMPL(a_pop_is_due, cell_op == OP_POP, flags.head_due)
    // burst counter stays within the cap
    `STQ_ASSERT_ALWAYS(a_pops_capped, pops_reg <= POP_W'(MAX_OUT))

endmodule

/* rtl/stq_cell.sv */
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted chain: holds a timer and takes from a neighbour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stq_cell #(
    parameter int ID_BITS   = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [2:0]              op,
    input  logic [ID_BITS-1:0]      key_id,
    input  logic [TIME_BITS-1:0]    key_exp,
    input  logic [TIME_BITS-1:0]    now,
    input  logic                    left_valid,
    input  logic [ID_BITS-1:0]      left_id,
    input  logic [TIME_BITS-1:0]    left_exp,
    input  logic                    left_ge,
    input  logic                    left_pair,
    input  logic                    right_valid,
    input  logic [ID_BITS-1:0]      right_id,
    input  logic [TIME_BITS-1:0]    right_exp,
    output logic                    valid,
    output logic [ID_BITS-1:0]      id,
    output logic [TIME_BITS-1:0]    exp,
    output stq_pkg::stq_cell_stat_t stat
);
    import stq_pkg::*;

    logic                 valid_reg, valid_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [TIME_BITS-1:0] exp_reg, exp_next;

    assign stat.match   = valid_reg && (id_reg == key_id);
    assign stat.slot_ge = !valid_reg || (exp_reg >= key_exp);
    assign stat.due     = valid_reg && (exp_reg <= now);
    assign stat.pair    = !valid_reg && right_valid;

    always_comb begin
        valid_next = valid_reg;
        id_next    = id_reg;
        exp_next   = exp_reg;
        unique case (op)
            OP_INSERT: begin
                // left neighbour moves up, the first slot empty or expiring at or after the key takes it
                priority if (left_ge) begin
                    valid_next = left_valid;
                    id_next    = left_id;
                    exp_next   = left_exp;
                end else if (stat.slot_ge) begin
                    valid_next = 1'b1;
                    id_next    = key_id;
                    exp_next   = key_exp;
                end
            end
            OP_KILL: begin
                if (stat.match) begin
                    valid_next = 1'b0;
                end
            end
            OP_COMPACT: begin
                // hole moves one slot to the right
                priority if (stat.pair) begin
                    valid_next = 1'b1;
                    id_next    = right_id;
                    exp_next   = right_exp;
                end else if (left_pair) begin
                    valid_next = 1'b0;
                end
            end
            OP_POP: begin
                valid_next = right_valid;
                id_next    = right_id;
                exp_next   = right_exp;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg  <= id_next;
        exp_reg <= exp_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign exp   = exp_reg;

endmodule

/* rtl/stq_chain.sv */
// ----------------------------------------------------------------------------
// stq_chain
// Row of DEPTH cells kept in ascending expiry order, slot 0 at the head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stq_chain #(
    parameter int DEPTH     = 32,
    parameter int ID_BITS   = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [2:0]           op,
    input  logic [ID_BITS-1:0]   key_id,
    input  logic [TIME_BITS-1:0] key_exp,
    input  logic [TIME_BITS-1:0] now,
    output logic [ID_BITS-1:0]   head_id,
    output stq_pkg::stq_flags_t  flags
);
    import stq_pkg::*;

    logic                 valid_q [DEPTH];
    logic [ID_BITS-1:0]   id_q    [DEPTH];
    logic [TIME_BITS-1:0] exp_q   [DEPTH];
    stq_cell_stat_t       stat_q  [DEPTH];
    logic [DEPTH-1:0]     match_vec;
    logic [DEPTH-1:0]     pair_vec;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                 l_valid, l_ge, l_pair, r_valid;
        logic [ID_BITS-1:0]   l_id, r_id;
        logic [TIME_BITS-1:0] l_exp, r_exp;

        if (i == 0) begin : g_first
            assign l_valid = 1'b0;
            assign l_id    = '0;
            assign l_exp   = '0;
            assign l_ge    = 1'b0;
            assign l_pair  = 1'b0;
        end else begin : g_inner_l
            assign l_valid = valid_q[i-1];
            assign l_id    = id_q[i-1];
            assign l_exp   = exp_q[i-1];
            assign l_ge    = stat_q[i-1].slot_ge;
            assign l_pair  = stat_q[i-1].pair;
        end

        if (i == DEPTH - 1) begin : g_last
            assign r_valid = 1'b0;
            assign r_id    = '0;
            assign r_exp   = '0;
        end else begin : g_inner_r
            assign r_valid = valid_q[i+1];
            assign r_id    = id_q[i+1];
            assign r_exp   = exp_q[i+1];
        end

        stq_cell #(
            .ID_BITS  (ID_BITS),
            .TIME_BITS(TIME_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (op),
            .key_id     (key_id),
            .key_exp    (key_exp),
            .now        (now),
            .left_valid (l_valid),
            .left_id    (l_id),
            .left_exp   (l_exp),
            .left_ge    (l_ge),
            .left_pair  (l_pair),
            .right_valid(r_valid),
            .right_id   (r_id),
            .right_exp  (r_exp),
            .valid      (valid_q[i]),
            .id         (id_q[i]),
            .exp        (exp_q[i]),
            .stat       (stat_q[i])
        );

        assign match_vec[i] = stat_q[i].match;
        assign pair_vec[i]  = stat_q[i].pair;
    end

    assign head_id        = id_q[0];
    assign flags.hit      = |match_vec;
    assign flags.full     = valid_q[DEPTH-1];
    assign flags.head_due = stat_q[0].due;
    assign flags.next_due = stat_q[1].due;
    assign flags.busy     = |pair_vec;

endmodule
